// ===== rtl/slcd_pkg.sv =====
// Shared constants for the serial line command decoder.
// Holds command codes, character codes and the prefix match function.
// No dependencies.
package slcd_pkg;

   // default line length before the write index wraps
   localparam int LINE_DEPTH_DEF = 50;

   // command codes on rsp_command_code
   localparam logic [3:0] CMD_NONE     = 4'd0;
   localparam logic [3:0] CMD_SETTIME  = 4'd2;
   localparam logic [3:0] CMD_PUMP_ON  = 4'd3;
   localparam logic [3:0] CMD_PUMP_OFF = 4'd4;

   // character codes
   localparam logic [7:0] CH_TAB   = 8'd9;
   localparam logic [7:0] CH_LF    = 8'd10;
   localparam logic [7:0] CH_CR    = 8'd13;
   localparam logic [7:0] CH_SPACE = 8'd32;
   localparam logic [7:0] CH_PLUS  = 8'd43;
   localparam logic [7:0] CH_MINUS = 8'd45;
   localparam logic [7:0] CH_ZERO  = 8'd48;
   localparam logic [7:0] CH_NINE  = 8'd57;

   // prefixes, right-justified: char i of a prefix sits at byte (len-1-i)
   localparam int NUM_PFX = 9;
   localparam int PFX_MAX = 8;
   localparam logic [PFX_MAX-1:0][7:0] PFX_TEXT [NUM_PFX] = '{
      "@html", "@setTime", "@pompOn", "@pompOff", "@lampOn",
      "@lampOff", "@fanOn", "@fanOff", "@ac"
   };
   localparam logic [3:0] PFX_LEN [NUM_PFX] = '{
      4'd5, 4'd8, 4'd7, 4'd8, 4'd7, 4'd8, 4'd6, 4'd7, 4'd3
   };

   // first prefix that matches the head of the line, or CMD_NONE
   function automatic logic [3:0] pfx_code(input logic [PFX_MAX-1:0][7:0] head);
      logic [3:0] code;
      logic       hit;
      code = CMD_NONE;
      for (int k = NUM_PFX - 1; k >= 0; k--) begin
         hit = 1'b1;
         for (int i = 0; i < PFX_MAX; i++) begin
            if (i < int'(PFX_LEN[k]) &&
                head[i] != PFX_TEXT[k][3'(int'(PFX_LEN[k]) - 1 - i)]) begin
               hit = 1'b0;
            end
         end
         if (hit) begin
            code = 4'(k + 1);
         end
      end
      return code;
   endfunction

endpackage

// ===== rtl/slcd_ram.sv =====
// Generic single write port, single read port RAM with registered read.
// No dependencies.
module slcd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 51
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// ===== rtl/serial_line_command_decoder.sv =====
// Top level of the serial line command decoder.
// Depends on slcd_pkg and slcd_ram.
//
// Usage:
//  - Input channel req_*: one received byte per word. Carriage return is
//    dropped, line feed ends the line, any other byte is stored in the line
//    store (write index wraps after LINE_DEPTH bytes).
//  - Result channel rsp_*: one word per line feed, carrying the command code
//    and the current pump number and time holding registers.
//  - A stored or dropped byte leaves the sequencer idle, ready for the next
//    byte. A line feed reads the first eight store entries, each read
//    followed by an evaluate state, matches the prefixes, then walks each
//    decimal field one byte at a time through the single read port of the
//    store, and loads the output register; no new byte is taken until the
//    sequencer is idle again.
//  - Reset clears the state machine, fill index, holding registers and the
//    per-entry valid bits, so the whole store reads as zero at once.
//  - A result waits in the output register while rsp_stall is high; bytes
//    are still stored meanwhile, but the next line feed holds in its final
//    step until the output register is free.
module serial_line_command_decoder #(
   parameter int LINE_DEPTH = slcd_pkg::LINE_DEPTH_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [3:0] rsp_command_code,
   output logic [7:0] rsp_pump_number,
   output logic [7:0] rsp_year,
   output logic [7:0] rsp_month,
   output logic [7:0] rsp_day,
   output logic [7:0] rsp_hour,
   output logic [7:0] rsp_minute,
   output logic [7:0] rsp_second
);
   import slcd_pkg::*;

   localparam int STORE_DEPTH = LINE_DEPTH + 1;
   localparam int AW          = $clog2(STORE_DEPTH);

   // sequencer states
   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_PFX_RD = 3'd1;
   localparam logic [2:0] S_PFX_EV = 3'd2;
   localparam logic [2:0] S_MATCH  = 3'd3;
   localparam logic [2:0] S_FLD_RD = 3'd4;
   localparam logic [2:0] S_FLD_EV = 3'd5;
   localparam logic [2:0] S_FINISH = 3'd6;

   // field targets
   localparam logic [2:0] FLD_YEAR   = 3'd0;
   localparam logic [2:0] FLD_MONTH  = 3'd1;
   localparam logic [2:0] FLD_DAY    = 3'd2;
   localparam logic [2:0] FLD_HOUR   = 3'd3;
   localparam logic [2:0] FLD_MINUTE = 3'd4;
   localparam logic [2:0] FLD_SECOND = 3'd5;
   localparam logic [2:0] FLD_PUMP   = 3'd6;

   // field offsets in the line
   localparam int SETTIME_BASE = 9;
   localparam int FIELD_STEP   = 3;
   localparam int PUMP_ON_POS  = 8;
   localparam int PUMP_OFF_POS = 9;

   logic [2:0]               state_ff, state_in;
   logic [AW-1:0]            fill_ff, fill_in;
   logic [STORE_DEPTH-1:0]   valid_ff, valid_in;
   logic                     valid_q_ff;
   logic [2:0]               cnt_ff, cnt_in;
   logic [PFX_MAX-1:0][7:0]  pfx_buf_ff, pfx_buf_in;
   logic [3:0]               code_ff, code_in;
   logic [2:0]               fld_sel_ff, fld_sel_in;
   logic [AW-1:0]            fld_base_ff, fld_base_in;
   logic [AW-1:0]            pos_ff, pos_in;
   logic [7:0]               acc_ff, acc_in;
   logic                     neg_ff, neg_in;
   logic                     ph_digit_ff, ph_digit_in;
   logic [7:0]               pump_ff, pump_in;
   logic [7:0]               year_ff, year_in;
   logic [7:0]               month_ff, month_in;
   logic [7:0]               day_ff, day_in;
   logic [7:0]               hour_ff, hour_in;
   logic [7:0]               minute_ff, minute_in;
   logic [7:0]               second_ff, second_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [3:0]               rsp_code_ff, rsp_code_in;
   logic [7:0]               rsp_pump_ff, rsp_pump_in;
   logic [7:0]               rsp_year_ff, rsp_year_in;
   logic [7:0]               rsp_month_ff, rsp_month_in;
   logic [7:0]               rsp_day_ff, rsp_day_in;
   logic [7:0]               rsp_hour_ff, rsp_hour_in;
   logic [7:0]               rsp_minute_ff, rsp_minute_in;
   logic [7:0]               rsp_second_ff, rsp_second_in;

   logic          req_acc;
   logic          ram_we;
   logic [AW-1:0] wr_idx;
   logic [AW-1:0] rd_addr;
   logic [7:0]    ram_q;
   logic [7:0]    rd_byte;
   logic          is_blank, is_digit, is_sign;
   logic [7:0]    dig_val;
   logic [7:0]    acc_step;
   logic [7:0]    fld_val;
   logic          fld_done;
   logic [3:0]    match_code;
   logic          rsp_free;

   // line store
   slcd_ram #(
      .WIDTH(8),
      .DEPTH(STORE_DEPTH)
   ) u_line_ram (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(wr_idx),
      .wr_data(req_rx_byte),
      .rd_addr(rd_addr),
      .rd_data(ram_q)
   );

   // handshake
   assign req_stall = (state_ff != S_IDLE);
   assign req_acc   = req_valid && !req_stall;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;

   // store write position, wrapping at the line length
   assign wr_idx = (fill_ff == AW'(LINE_DEPTH)) ? '0 : fill_ff;
   assign ram_we = req_acc && req_rx_byte != CH_CR && req_rx_byte != CH_LF;

   // read address: prefix bytes, then field bytes
   assign rd_addr = (state_ff == S_PFX_RD) ? AW'(cnt_ff) : pos_ff;
   // never-written or cleared entries read as zero
   assign rd_byte = valid_q_ff ? ram_q : 8'd0;

   // character classes for the field scan
   assign is_blank = rd_byte == CH_SPACE || (rd_byte >= CH_TAB && rd_byte <= CH_CR);
   assign is_digit = rd_byte >= CH_ZERO && rd_byte <= CH_NINE;
   assign is_sign  = rd_byte == CH_PLUS || rd_byte == CH_MINUS;
   assign dig_val  = rd_byte - CH_ZERO;
   assign acc_step = (acc_ff << 3) + (acc_ff << 1) + dig_val;
   assign fld_val  = neg_ff ? 8'(8'd0 - acc_ff) : acc_ff;

   assign match_code = pfx_code(pfx_buf_ff);

   // field scan ends at the first byte that does not continue it
   always_comb begin
      if (ph_digit_ff) begin
         fld_done = !is_digit;
      end else begin
         fld_done = !is_blank && !is_sign && !is_digit;
      end
   end

   // sequencer
   always_comb begin
      state_in    = state_ff;
      fill_in     = fill_ff;
      valid_in    = valid_ff;
      cnt_in      = cnt_ff;
      pfx_buf_in  = pfx_buf_ff;
      code_in     = code_ff;
      fld_sel_in  = fld_sel_ff;
      fld_base_in = fld_base_ff;
      pos_in      = pos_ff;
      acc_in      = acc_ff;
      neg_in      = neg_ff;
      ph_digit_in = ph_digit_ff;
      pump_in     = pump_ff;
      year_in     = year_ff;
      month_in    = month_ff;
      day_in      = day_ff;
      hour_in     = hour_ff;
      minute_in   = minute_ff;
      second_in   = second_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_code_in   = rsp_code_ff;
      rsp_pump_in   = rsp_pump_ff;
      rsp_year_in   = rsp_year_ff;
      rsp_month_in  = rsp_month_ff;
      rsp_day_in    = rsp_day_ff;
      rsp_hour_in   = rsp_hour_ff;
      rsp_minute_in = rsp_minute_ff;
      rsp_second_in = rsp_second_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_acc) begin
               if (req_rx_byte == CH_LF) begin
                  cnt_in   = '0;
                  state_in = S_PFX_RD;
               end else if (req_rx_byte != CH_CR) begin
                  // byte goes in, the entry after it becomes the terminator
                  valid_in[wr_idx]      = 1'b1;
                  valid_in[wr_idx + 1'b1] = 1'b0;
                  fill_in               = wr_idx + 1'b1;
               end
            end
         end
         S_PFX_RD: begin
            state_in = S_PFX_EV;
         end
         S_PFX_EV: begin
            pfx_buf_in[cnt_ff] = rd_byte;
            cnt_in             = cnt_ff + 3'd1;
            state_in           = (cnt_ff == 3'(PFX_MAX - 1)) ? S_MATCH : S_PFX_RD;
         end
         S_MATCH: begin
            code_in     = match_code;
            acc_in      = '0;
            neg_in      = 1'b0;
            ph_digit_in = 1'b0;
            state_in    = S_FLD_RD;
            case (match_code)
               CMD_SETTIME: begin
                  fld_sel_in  = FLD_YEAR;
                  fld_base_in = AW'(SETTIME_BASE);
                  pos_in      = AW'(SETTIME_BASE);
               end
               CMD_PUMP_ON: begin
                  fld_sel_in = FLD_PUMP;
                  pos_in     = AW'(PUMP_ON_POS);
               end
               CMD_PUMP_OFF: begin
                  fld_sel_in = FLD_PUMP;
                  pos_in     = AW'(PUMP_OFF_POS);
               end
               default: begin
                  state_in = S_FINISH;
               end
            endcase
         end
         S_FLD_RD: begin
            state_in = S_FLD_EV;
         end
         S_FLD_EV: begin
            if (fld_done) begin
               // field finished: load its register, go on to the next one or finish
               case (fld_sel_ff)
                  FLD_YEAR:   year_in   = fld_val;
                  FLD_MONTH:  month_in  = fld_val;
                  FLD_DAY:    day_in    = fld_val;
                  FLD_HOUR:   hour_in   = fld_val;
                  FLD_MINUTE: minute_in = fld_val;
                  FLD_SECOND: second_in = fld_val;
                  default:    pump_in   = fld_val;
               endcase
               acc_in      = '0;
               neg_in      = 1'b0;
               ph_digit_in = 1'b0;
               if (fld_sel_ff < FLD_SECOND) begin
                  fld_sel_in  = fld_sel_ff + 3'd1;
                  fld_base_in = fld_base_ff + AW'(FIELD_STEP);
                  pos_in      = fld_base_ff + AW'(FIELD_STEP);
                  state_in    = S_FLD_RD;
               end else begin
                  state_in = S_FINISH;
               end
            end else begin
               pos_in   = pos_ff + 1'b1;
               state_in = S_FLD_RD;
               if (ph_digit_ff) begin
                  acc_in = acc_step;
               end else if (is_sign) begin
                  neg_in      = (rd_byte == CH_MINUS);
                  ph_digit_in = 1'b1;
               end else if (is_digit) begin
                  acc_in      = dig_val;
                  ph_digit_in = 1'b1;
               end
            end
         end
         S_FINISH: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_code_in   = code_ff;
               rsp_pump_in   = pump_ff;
               rsp_year_in   = year_ff;
               rsp_month_in  = month_ff;
               rsp_day_in    = day_ff;
               rsp_hour_in   = hour_ff;
               rsp_minute_in = minute_ff;
               rsp_second_in = second_ff;
               // clear the line: entry 0 reads as zero again
               fill_in     = '0;
               valid_in[0] = 1'b0;
               state_in    = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control and holding registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         fill_ff      <= '0;
         valid_ff     <= '0;
         pump_ff      <= '0;
         year_ff      <= '0;
         month_ff     <= '0;
         day_ff       <= '0;
         hour_ff      <= '0;
         minute_ff    <= '0;
         second_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         valid_ff     <= valid_in;
         pump_ff      <= pump_in;
         year_ff      <= year_in;
         month_ff     <= month_in;
         day_ff       <= day_in;
         hour_ff      <= hour_in;
         minute_ff    <= minute_in;
         second_ff    <= second_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      valid_q_ff    <= valid_ff[rd_addr];
      cnt_ff        <= cnt_in;
      pfx_buf_ff    <= pfx_buf_in;
      code_ff       <= code_in;
      fld_sel_ff    <= fld_sel_in;
      fld_base_ff   <= fld_base_in;
      pos_ff        <= pos_in;
      acc_ff        <= acc_in;
      neg_ff        <= neg_in;
      ph_digit_ff   <= ph_digit_in;
      rsp_code_ff   <= rsp_code_in;
      rsp_pump_ff   <= rsp_pump_in;
      rsp_year_ff   <= rsp_year_in;
      rsp_month_ff  <= rsp_month_in;
      rsp_day_ff    <= rsp_day_in;
      rsp_hour_ff   <= rsp_hour_in;
      rsp_minute_ff <= rsp_minute_in;
      rsp_second_ff <= rsp_second_in;
   end

   // outputs
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_command_code = rsp_code_ff;
   assign rsp_pump_number  = rsp_pump_ff;
   assign rsp_year         = rsp_year_ff;
   assign rsp_month        = rsp_month_ff;
   assign rsp_day          = rsp_day_ff;
   assign rsp_hour         = rsp_hour_ff;
   assign rsp_minute       = rsp_minute_ff;
   assign rsp_second       = rsp_second_ff;

endmodule
